// File: rtl/core/scrf_pkg.sv
// Package for the secant cubic root finder: constants, status codes, FSM states,
// and the controller-to-datapath command and status structs. No dependencies.
`default_nettype none
package scrf_pkg;
    localparam int unsigned FracBitsDef = 16;
    localparam int unsigned WordBitsDef = 32;
    localparam int unsigned NumRegs     = 6;

    localparam logic [2:0] RegCoeff0 = 3'd0;
    localparam logic [2:0] RegCoeff1 = 3'd1;
    localparam logic [2:0] RegCoeff2 = 3'd2;
    localparam logic [2:0] RegCoeff3 = 3'd3;
    localparam logic [2:0] RegTol    = 3'd4;
    localparam logic [2:0] RegMaxIt  = 3'd5;

    localparam logic [1:0] StConverged = 2'd0;
    localparam logic [1:0] StZeroDen   = 2'd1;
    localparam logic [1:0] StIterLimit = 2'd2;
    localparam logic [1:0] StOverflow  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_EVAL0,
        S_EVAL1,
        S_DEN,
        S_MULA,
        S_MULB,
        S_NUM,
        S_DIV,
        S_ERR,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic eval_start;
        logic eval_sel;   // 0: older guess, 1: newer guess
        logic den;
        logic mul_start;
        logic mul_sel;    // 0: older*f1, 1: newer*f0
        logic div_start;
        logic err;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic eval_done;
        logic mul_done;
        logic div_done;
        logic den_zero;
        logic ovf;
        logic conv;
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/core/scrf_if.sv
// Valid/ready channel interfaces: item, result, and configuration write.
// Depends on nothing.
`default_nettype none
interface scrf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] first_guess;
    logic [31:0] second_guess;
    modport source (output valid, first_guess, second_guess, input ready);
    modport sink   (input valid, first_guess, second_guess, output ready);
endinterface

interface scrf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] root;
    logic [7:0]  iterations_used;
    logic [1:0]  status;
    modport source (output valid, root, iterations_used, status, input ready);
    modport sink   (input valid, root, iterations_used, status, output ready);
endinterface

interface scrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/scrf_mul.sv
// Sequential signed fixed-point multiplier, shift-add over the WORD_BITS multiplier bits.
// Floors the product by FRAC_BITS and saturates. Uses scrf_pkg.
`default_nettype none
module scrf_mul import scrf_pkg::*; #(
    parameter int unsigned FRAC_BITS = FracBitsDef,
    parameter int unsigned WORD_BITS = WordBitsDef
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [WORD_BITS-1:0] i_a,
    input  wire logic signed [WORD_BITS-1:0] i_b,
    output logic                             o_done,
    output logic signed [WORD_BITS-1:0]      o_p,
    output logic                             o_ovf
);
    localparam int unsigned PW = 2 * WORD_BITS;
    localparam int unsigned CW = $clog2(WORD_BITS + 1);

    logic [PW-1:0]        r_acc, r_mcand;
    logic [WORD_BITS-1:0] r_mplier;
    logic                 r_neg, r_busy;
    logic [CW-1:0]        r_cnt;
    logic [WORD_BITS-1:0] ua, ub;
    logic [PW-1:0]        q;
    logic                 rem_nz;
    logic [PW:0]          qr;
    logic [PW:0]          lim;
    logic [PW:0]          qs;

    assign ua = i_a[WORD_BITS-1] ? WORD_BITS'(-i_a) : WORD_BITS'(i_a);
    assign ub = i_b[WORD_BITS-1] ? WORD_BITS'(-i_b) : WORD_BITS'(i_b);

    // shift-add loop, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_acc    <= '0;
                r_mcand  <= PW'(ua);
                r_mplier <= ub;
                r_neg    <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
                r_cnt    <= CW'(WORD_BITS);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_p    <= r_neg ? -WORD_BITS'(qs) : WORD_BITS'(qs);
                    o_ovf  <= (qs != qr);
                end else begin
                    if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                end
            end
        end
    end

    // magnitude scaling, floor correction and clamp
    always_comb begin
        q      = r_acc >> FRAC_BITS;
        rem_nz = |r_acc[FRAC_BITS-1:0];
        qr     = {1'b0, q} + (PW+1)'(r_neg & rem_nz);
        lim    = (PW+1)'({1'b0, {(WORD_BITS-1){1'b1}}}) + (PW+1)'(r_neg);
        qs     = (qr > lim) ? lim : qr;
    end
endmodule
`default_nettype wire

// File: rtl/core/scrf_div.sv
// Restoring divider for fixed-point quotient (n << FRAC_BITS) / d, truncating.
// One quotient bit per cycle, saturating result. Uses scrf_pkg.
`default_nettype none
module scrf_div import scrf_pkg::*; #(
    parameter int unsigned FRAC_BITS = FracBitsDef,
    parameter int unsigned WORD_BITS = WordBitsDef
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [WORD_BITS-1:0] i_n,
    input  wire logic signed [WORD_BITS-1:0] i_d,
    output logic                             o_done,
    output logic signed [WORD_BITS-1:0]      o_q,
    output logic                             o_ovf
);
    localparam int unsigned NW = WORD_BITS + FRAC_BITS;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0]        r_num, r_q;
    logic [WORD_BITS:0]   r_rem;
    logic [WORD_BITS-1:0] r_den;
    logic                 r_neg, r_busy;
    logic [CW-1:0]        r_cnt;
    logic [WORD_BITS-1:0] un, ud;
    logic [WORD_BITS:0]   trial;
    logic [NW-1:0]        lim;

    assign un    = i_n[WORD_BITS-1] ? WORD_BITS'(-i_n) : WORD_BITS'(i_n);
    assign ud    = i_d[WORD_BITS-1] ? WORD_BITS'(-i_d) : WORD_BITS'(i_d);
    assign trial = {r_rem[WORD_BITS-1:0], r_num[NW-1]};
    assign lim   = NW'({1'b0, {(WORD_BITS-1){1'b1}}}) + NW'(r_neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= {un, {FRAC_BITS{1'b0}}};
                r_den  <= ud;
                r_rem  <= '0;
                r_q    <= '0;
                r_neg  <= i_n[WORD_BITS-1] ^ i_d[WORD_BITS-1];
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_ovf  <= (r_q > lim);
                    o_q    <= r_neg ? -WORD_BITS'((r_q > lim) ? lim : r_q)
                                    :  WORD_BITS'((r_q > lim) ? lim : r_q);
                end else begin
                    // one quotient bit per cycle
                    if (trial >= {1'b0, r_den}) begin
                        r_rem <= trial - {1'b0, r_den};
                        r_q   <= {r_q[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_q   <= {r_q[NW-2:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/scrf_dp.sv
// Datapath: guess registers, Horner evaluation on the shared multiplier,
// secant numerator/denominator and divider. Uses scrf_pkg, scrf_mul, scrf_div.
`default_nettype none
module scrf_dp import scrf_pkg::*; #(
    parameter int unsigned FRAC_BITS = FracBitsDef,
    parameter int unsigned WORD_BITS = WordBitsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_x0,
    input  wire logic [31:0] i_x1,
    input  wire logic [31:0] i_c0,
    input  wire logic [31:0] i_c1,
    input  wire logic [31:0] i_c2,
    input  wire logic [31:0] i_c3,
    input  wire logic [30:0] i_tol,
    output t_stat            o_stat,
    output logic [31:0]      o_root,
    output logic             o_root_clip
);
    localparam int unsigned EW = (WORD_BITS > 32) ? WORD_BITS : 32;
    localparam logic signed [EW:0] WMax = (EW+1)'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic signed [EW:0] WMin = -WMax - (EW+1)'(1);

    typedef logic signed [WORD_BITS-1:0] t_w;

    t_w         r_x0, r_x1, r_x2, r_f0, r_f1, r_den, r_pa, r_p;
    logic       r_ovf, r_conv, r_eval, r_nextdone;
    logic       r_eval_done, r_mul_done;
    logic [1:0] r_k;
    t_w         mul_a, mul_b, mul_p, div_q;
    logic       mul_start, mul_done, mul_ovf, div_done, div_ovf;
    t_w         ck, s0, s1, cin;
    logic       o0, o1, oc;
    t_w         ldx0, ldx1;
    logic       lo0, lo1;
    t_w         e_abs;
    logic       e_ovf;

    // saturating add/sub of two words
    function automatic t_w sat_add(input t_w a, input t_w b, input logic sub,
                                   output logic ov);
        logic signed [WORD_BITS:0] s;
        begin
            s  = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
                     : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
            ov = (s[WORD_BITS] != s[WORD_BITS-1]);
            sat_add = ov ? (s[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                         : {1'b0, {(WORD_BITS-1){1'b1}}})
                         : s[WORD_BITS-1:0];
        end
    endfunction

    // 32-bit value into the word, saturating when the word is narrower
    function automatic t_w fit(input logic [31:0] v, output logic ov);
        logic signed [EW:0] e;
        begin
            e   = (EW+1)'(signed'(v));
            ov  = (e > WMax) || (e < WMin);
            fit = (e > WMax) ? WMax[WORD_BITS-1:0]
                : (e < WMin) ? WMin[WORD_BITS-1:0] : e[WORD_BITS-1:0];
        end
    endfunction

    always_comb begin
        ldx0 = fit(i_x0, lo0);
        ldx1 = fit(i_x1, lo1);
        case (r_k)
            2'd2:    cin = fit(i_c2, oc);
            2'd1:    cin = fit(i_c1, oc);
            default: cin = fit(i_c0, oc);
        endcase
        ck    = fit(i_c3, o0);
        s0    = sat_add(cin, mul_p, 1'b0, o1);
        e_abs = sat_add(div_q, r_x1, 1'b1, e_ovf);
    end

    logic ov_a, ov_b;
    t_w   num, dsub, e2, e_neg;
    logic ov_c, ov_neg;
    always_comb begin
        s1    = sat_add(r_pa, mul_p, 1'b1, ov_a);
        dsub  = sat_add(r_f1, r_f0, 1'b1, ov_b);
        // absolute change; negating the most negative word saturates
        e_neg = sat_add('0, e_abs, 1'b1, ov_neg);
        e2    = e_abs[WORD_BITS-1] ? e_neg : e_abs;
        ov_c  = e_abs[WORD_BITS-1] & ov_neg;
        num   = s1;
    end

    // multiplier operands: Horner step or secant products
    assign mul_a = r_eval ? r_p : (i_cmd.mul_sel ? r_x1 : r_x0);
    assign mul_b = r_eval ? (i_cmd.eval_sel ? r_x1 : r_x0)
                          : (i_cmd.mul_sel ? r_f0 : r_f1);
    assign mul_start = i_cmd.mul_start | r_nextdone;

    scrf_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p), .o_ovf(mul_ovf)
    );

    scrf_div #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_n(r_pa), .i_d(r_den), .o_done(div_done), .o_q(div_q), .o_ovf(div_ovf)
    );

    // working registers and sticky overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf       <= 1'b0;
            r_eval      <= 1'b0;
            r_nextdone  <= 1'b0;
            r_conv      <= 1'b0;
            r_k         <= '0;
            r_eval_done <= 1'b0;
            r_mul_done  <= 1'b0;
        end else begin
            r_nextdone  <= 1'b0;
            r_eval_done <= 1'b0;
            r_mul_done  <= 1'b0;
            if (i_cmd.load) begin
                r_x0  <= ldx0;
                r_x1  <= ldx1;
                r_ovf <= lo0 | lo1;
            end
            if (i_cmd.eval_start) begin
                // Horner starts at the top coefficient, then three mul-add steps
                r_p        <= ck;
                r_ovf      <= r_ovf | o0;
                r_eval     <= 1'b1;
                r_k        <= 2'd2;
                r_nextdone <= 1'b1;
            end else if (r_eval && mul_done) begin
                r_p   <= s0;
                r_ovf <= r_ovf | mul_ovf | oc | o1;
                if (r_k == 2'd0) begin
                    r_eval      <= 1'b0;
                    r_eval_done <= 1'b1;
                    if (i_cmd.eval_sel) r_f1 <= s0; else r_f0 <= s0;
                end else begin
                    r_k        <= r_k - 2'd1;
                    r_nextdone <= 1'b1;
                end
            end
            if (i_cmd.den) begin
                r_den <= dsub;
                r_ovf <= r_ovf | ov_b;
            end
            if (i_cmd.mul_start) r_k <= {1'b0, i_cmd.mul_sel};
            // second product is subtracted from the first as it lands
            if (!r_eval && mul_done) begin
                r_mul_done <= 1'b1;
                r_ovf <= r_ovf | mul_ovf | (r_k[0] & ov_a);
                if (r_k[0]) r_pa <= num; else r_pa <= mul_p;
            end
            if (div_done) begin
                r_x2  <= div_q;
                r_ovf <= r_ovf | div_ovf | e_ovf | ov_c;
                r_conv <= (EW+1)'($unsigned(e2)) < (EW+1)'(i_tol);
            end
            if (i_cmd.err) begin
                r_x0 <= r_x1;
                r_x1 <= r_x2;
            end
        end
    end

    assign o_stat.eval_done = r_eval_done;
    assign o_stat.mul_done  = r_mul_done;
    assign o_stat.div_done  = div_done;
    assign o_stat.den_zero  = (r_den == '0);
    assign o_stat.ovf       = r_ovf;
    assign o_stat.conv      = r_conv;

    // root from x2 (or x1 on flat secant, which equals r_x1), clamped to 32 bits
    logic signed [EW:0] rx;
    assign rx          = (EW+1)'(r_x1);
    assign o_root_clip = (rx > (EW+1)'(32'sh7FFFFFFF)) || (rx < -(EW+1)'(33'sh080000000));
    assign o_root      = (rx > (EW+1)'(32'sh7FFFFFFF)) ? 32'h7FFFFFFF
                       : (rx < -(EW+1)'(33'sh080000000)) ? 32'h80000000 : rx[31:0];
endmodule
`default_nettype wire

// File: rtl/core/scrf_ctrl.sv
// Controller state machine sequencing the secant steps. Uses scrf_pkg.
`default_nettype none
module scrf_ctrl import scrf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_max_it,
    input  wire t_stat      i_stat,
    input  wire logic       i_root_clip,
    output t_cmd            o_cmd,
    output logic [7:0]      o_iters,
    output logic [1:0]      o_status
);
    t_state     r_state, n_state;
    logic [7:0] r_cnt, n_cnt, limit;
    logic [1:0] r_st, n_st;

    assign limit = (i_max_it == 8'd0) ? 8'd1 : i_max_it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_st    <= StIterLimit;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_st    <= n_st;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_st        = r_st;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                n_cnt            = r_cnt + 8'd1;
                o_cmd.eval_start = 1'b1;
                n_state          = S_EVAL0;
            end
            S_EVAL0: if (i_stat.eval_done) begin
                o_cmd.eval_start = 1'b1;
                o_cmd.eval_sel   = 1'b1;
                n_state          = S_EVAL1;
            end
            S_EVAL1: begin
                o_cmd.eval_sel = 1'b1;
                if (i_stat.eval_done) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_state   = S_MULA;
            end
            S_MULA: begin
                if (i_stat.den_zero) begin
                    n_st    = i_stat.ovf ? StOverflow : StZeroDen;
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_MULB;
                end
            end
            S_MULB: if (i_stat.mul_done) begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = 1'b1;
                n_state         = S_NUM;
            end
            S_NUM: if (i_stat.mul_done) begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: if (i_stat.div_done) begin
                n_state = S_ERR;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                if (i_stat.ovf) begin
                    n_st = StOverflow; n_state = S_DONE;
                end else if (i_stat.conv) begin
                    n_st = StConverged; n_state = S_DONE;
                end else if (r_cnt >= limit) begin
                    n_st = StIterLimit; n_state = S_DONE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_iters  = r_cnt;
    assign o_status = i_root_clip ? StOverflow : r_st;
endmodule
`default_nettype wire

// File: rtl/core/secant_cubic_root_finder.sv
// Secant cubic root finder, top level: configuration registers, controller
// and datapath. Depends on scrf_pkg, scrf_if, scrf_ctrl, scrf_dp.
`default_nettype none
// Takes x0 and x1 on the input channel and runs secant steps on
// f(x) = c3 x^3 + c2 x^2 + c1 x + c0 in signed fixed point, Horner's rule,
// returning one result (root, steps used, status) per item. One item at a
// time. Each step runs eight products on the shared serial multiplier and
// one division, in Q16.16 with the default parameters. The result is
// offered once the last step ends (a flat secant ends its last step before
// the secant products and division), and input is taken again the cycle
// after the result transfer. Configuration writes are taken at any time and
// must only be done while idle.
module secant_cubic_root_finder import scrf_pkg::*; #(
    parameter int unsigned FRAC_BITS = FracBitsDef,
    parameter int unsigned WORD_BITS = WordBitsDef
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    scrf_in_if.sink    in_ch,
    scrf_out_if.source out_ch,
    scrf_cfg_if.sink   cfg_ch
);
    logic [31:0] r_c0, r_c1, r_c2, r_c3;
    logic [30:0] r_tol;
    logic [7:0]  r_max_it;
    t_cmd        cmd;
    t_stat       stat;
    logic        root_clip;

    // configuration register file
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0;
            r_tol <= 31'd1; r_max_it <= 8'd64;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                RegCoeff0: r_c0     <= cfg_ch.data;
                RegCoeff1: r_c1     <= cfg_ch.data;
                RegCoeff2: r_c2     <= cfg_ch.data;
                RegCoeff3: r_c3     <= cfg_ch.data;
                RegTol:    r_tol    <= cfg_ch.data[30:0];
                RegMaxIt:  r_max_it <= cfg_ch.data[7:0];
                default: ;
            endcase
        end
    end

    scrf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_max_it(r_max_it), .i_stat(stat), .i_root_clip(root_clip),
        .o_cmd(cmd), .o_iters(out_ch.iterations_used), .o_status(out_ch.status)
    );

    scrf_dp #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_x0(in_ch.first_guess), .i_x1(in_ch.second_guess),
        .i_c0(r_c0), .i_c1(r_c1), .i_c2(r_c2), .i_c3(r_c3), .i_tol(r_tol),
        .o_stat(stat), .o_root(out_ch.root), .o_root_clip(root_clip)
    );

    // one item in flight: no input accepted while a result is offered
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    // a result never shows zero steps
    a_iters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> out_ch.iterations_used != 8'd0) else $error("zero steps");
    // the load command only follows an input transfer
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (in_ch.valid && in_ch.ready)) else $error("load without transfer");
endmodule
`default_nettype wire
